// File: design/rtm_pkg.sv
`default_nettype none
package rtm_pkg;
    localparam int unsigned EXP_BITS_DEF = 31;
    localparam logic [29:0] MODP = 30'd1000000007;
    localparam int DIM = 3;
    typedef logic [29:0] t_elem;
endpackage
`default_nettype wire

// File: design/rtm_mulmod.sv
`default_nettype none
// Modular multiplier, three register stages: product, quotient estimate, remainder.
// Two conditional subtracts at the output finish the reduction.
module rtm_mulmod
    import rtm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire t_elem i_a,
    input  wire t_elem i_b,
    output t_elem      o_p
);
    // floor(2^61 / P); product < 2^60, so product >> 29 fits in 31 bits.
    localparam logic [63:0] RECIP_FULL = (64'd1 << 61) / {34'd0, MODP};
    localparam logic [31:0] RECIP = RECIP_FULL[31:0];
    logic [59:0] r_prod;
    logic [31:0] r_plo;
    logic [29:0] r_q;
    logic [31:0] r_rem;
    logic [62:0] q_full;
    logic [31:0] rem1;
    logic [31:0] rem2;
    logic        unused;

    // q = floor((x >> 29) * RECIP / 2^32) underestimates x / P by at most 2,
    // so the remainder stays below 3P and fits in 32 bits.
    always_comb begin
        q_full = {32'd0, r_prod[59:29]} * {31'd0, RECIP};
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {30'd0, i_a} * {30'd0, i_b};
        r_plo  <= r_prod[31:0];
        r_q    <= q_full[61:32];
        r_rem  <= r_plo - ({2'd0, r_q} * {2'd0, MODP});
    end

    always_comb begin
        rem1 = (r_rem >= {2'd0, MODP}) ? r_rem - {2'd0, MODP} : r_rem;
        rem2 = (rem1 >= {2'd0, MODP}) ? rem1 - {2'd0, MODP} : rem1;
    end
    assign o_p = rem2[29:0];
    assign unused = ^{q_full[62], q_full[31:0], rem2[31:30]};
endmodule
`default_nettype wire

// File: design/recurrence_term_by_matrix_power_mod_unit.sv
`default_nettype none
// Returns a(n) mod 1000000007 for a(n)=a(n-1)+a(n-3), a(1..3)=1. Each beat runs
// square-and-multiply over EXP_BITS exponent bits on one shared three-stage modular
// multiplier: per bit a 27-product matrix multiply (when the bit is set) and a square,
// each product issued and awaited in turn, then a vector product. Indices of 3 or less
// skip the matrix work and go straight to the output.
// The input stalls while an item is in progress; the result sits in an output register.
module recurrence_term_by_matrix_power_mod_unit
    import rtm_pkg::*;
#(
    parameter int unsigned EXP_BITS = EXP_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [30:0] i_term_index,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [29:0]      o_term_value
);
    localparam int BW = $clog2(EXP_BITS + 1);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_MUL = 5'b00010, S_WAIT = 5'b00100,
        S_NEXT = 5'b01000, S_OUT = 5'b10000
    } t_state;
    typedef enum logic [1:0] {OP_ACC, OP_SQR, OP_VEC} t_op;

    t_state r_state;
    t_op r_op;
    t_elem r_base [9];
    t_elem r_acc [9];
    t_elem r_tmp [9];
    logic [31:0] r_ex;
    logic [BW-1:0] r_bit;
    logic [1:0] r_i, r_j, r_k;
    logic [1:0] r_wait;
    t_elem r_sum;
    logic [29:0] r_out;
    logic r_ov;
    t_elem ma, mb, mp;
    logic [30:0] s;
    t_elem sum;

    // row-major index of a 3x3 element
    function automatic logic [3:0] f_idx(logic [1:0] row, logic [1:0] col);
        return {1'b0, row, 1'b0} + {2'b0, row} + {2'b0, col};
    endfunction

    rtm_mulmod u_mul (.i_clk(i_clk), .i_a(ma), .i_b(mb), .o_p(mp));

    always_comb begin
        ma = '0; mb = '0;
        unique case (r_op)
            OP_ACC: begin ma = r_acc[f_idx(r_i, r_k)]; mb = r_base[f_idx(r_k, r_j)]; end
            OP_SQR: begin ma = r_base[f_idx(r_i, r_k)]; mb = r_base[f_idx(r_k, r_j)]; end
            OP_VEC: begin ma = 30'd1; mb = r_acc[f_idx(r_k, r_j)]; end
            default: ;
        endcase
        s = {1'b0, r_sum} + {1'b0, mp};
        sum = (s >= {1'b0, MODP}) ? 30'(s - {1'b0, MODP}) : s[29:0];
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ov;
    assign o_term_value = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ov <= 1'b0; r_op <= OP_ACC;
        end else begin
            if (r_state == S_OUT && (!r_ov || !i_stall)) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    if (i_term_index <= 31'd3) begin
                        r_tmp[0] <= 30'd1; r_state <= S_OUT;
                    end else begin
                        r_ex <= 32'(i_term_index - 31'd3);
                        r_bit <= '0;
                        for (int e = 0; e < 9; e++) begin
                            r_acc[e] <= (e == 0 || e == 4 || e == 8) ? 30'd1 : 30'd0;
                            r_base[e] <= (e == 0 || e == 1 || e == 5 || e == 6)
                                ? 30'd1 : 30'd0;
                        end
                        r_op <= (i_term_index[0] == 1'b0) ? OP_ACC : OP_SQR;
                        r_i <= '0; r_j <= '0; r_k <= '0; r_sum <= '0;
                        r_wait <= '0; r_state <= S_MUL;
                    end
                end
                S_MUL: begin r_wait <= '0; r_state <= S_WAIT; end
                S_WAIT: if (r_wait == 2'd2) begin
                    r_wait <= '0;
                    if (r_k == 2'd2) begin
                        r_tmp[f_idx(r_i, r_j)] <= sum; r_sum <= '0; r_k <= '0;
                        if (r_j == 2'd2) begin
                            r_j <= '0;
                            if (r_i == 2'd2 || r_op == OP_VEC) begin
                                r_i <= '0; r_state <= S_NEXT;
                            end else begin r_i <= r_i + 2'd1; r_state <= S_MUL; end
                        end else begin r_j <= r_j + 2'd1; r_state <= S_MUL; end
                    end else begin
                        r_sum <= sum; r_k <= r_k + 2'd1; r_state <= S_MUL;
                    end
                end else r_wait <= r_wait + 2'd1;
                S_NEXT: begin
                    unique case (r_op)
                        OP_ACC: begin
                            for (int e = 0; e < 9; e++) r_acc[e] <= r_tmp[e];
                            r_op <= OP_SQR; r_state <= S_MUL;
                        end
                        OP_SQR: begin
                            for (int e = 0; e < 9; e++) r_base[e] <= r_tmp[e];
                            if (r_bit == BW'(EXP_BITS - 1)) begin
                                r_op <= OP_VEC;
                            end else begin
                                r_bit <= r_bit + 1'b1;
                                r_op <= r_ex[r_bit + 1'b1] ? OP_ACC : OP_SQR;
                            end
                            r_state <= S_MUL;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                // result waits in r_tmp[0] until the output register is free
                S_OUT: if (!r_ov || !i_stall) begin
                    r_out <= r_tmp[0]; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_term_value < MODP)) else $error("result out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_term_value)))
        else $error("result lost");
`endif
endmodule
`default_nettype wire
